### src/mmd_pkg.sv
// Shared constants for the multilevel min/max decimator.
// Used by every module of the block; depends on nothing.
package mmd_pkg;

   localparam int NUM_LEVELS_DEFAULT   = 16;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;

   // Configuration register file.
   localparam int CFG_WIDTH      = 5;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [CFG_WIDTH-1:0] LEVELS_IN_USE_RESET = 5'd16;

   // Register index of levels_in_use (byte address is four times this).
   localparam logic [0:0] REG_LEVELS_IN_USE = 1'b0;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

endpackage

### src/mmd_front.sv
// Front part: accepts samples, updates the running min/max of every level and
// classifies which levels release a result. Depends on mmd_pkg.
module mmd_front #(
   parameter int NUM_LEVELS   = mmd_pkg::NUM_LEVELS_DEFAULT,
   parameter int SAMPLE_WIDTH = mmd_pkg::SAMPLE_WIDTH_DEFAULT,
   localparam int CW = (NUM_LEVELS > 1) ? NUM_LEVELS - 1 : 1,
   localparam int EW = 2 * NUM_LEVELS + 2 * NUM_LEVELS * SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [mmd_pkg::CFG_WIDTH-1:0]  levels_in_use_i,
   input  logic                           sample_valid_i,
   output logic                           sample_ready_o,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
   input  logic                           stream_end_i,
   input  logic                           queue_full_i,
   output logic                           push_o,
   output logic [EW-1:0]                  push_data_o
);

   logic [CW-1:0] count_ff, count_in;
   logic signed [SAMPLE_WIDTH-1:0] lvl_min_ff [NUM_LEVELS];
   logic signed [SAMPLE_WIDTH-1:0] lvl_max_ff [NUM_LEVELS];
   logic signed [SAMPLE_WIDTH-1:0] lvl_min_in [NUM_LEVELS];
   logic signed [SAMPLE_WIDTH-1:0] lvl_max_in [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] emit_mask;
   logic [NUM_LEVELS-1:0] flush_mask;
   logic [NUM_LEVELS*SAMPLE_WIDTH-1:0] min_flat;
   logic [NUM_LEVELS*SAMPLE_WIDTH-1:0] max_flat;
   logic [mmd_pkg::CFG_WIDTH-1:0] used;
   logic accept;

   assign sample_ready_o = !queue_full_i;
   assign accept         = sample_valid_i && sample_ready_o;
   assign push_o         = accept;

   // Zero acts as one level, anything above the level count as all levels.
   always_comb begin
      if (levels_in_use_i == '0) begin
         used = mmd_pkg::CFG_WIDTH'(1);
      end else if (levels_in_use_i > mmd_pkg::CFG_WIDTH'(NUM_LEVELS)) begin
         used = mmd_pkg::CFG_WIDTH'(NUM_LEVELS);
      end else begin
         used = levels_in_use_i;
      end
   end

   // Level k's bucket is aligned to the low k bits of the sample count.
   always_comb begin
      logic [CW-1:0] kmask;
      logic first;
      logic full;
      for (int k = 0; k < NUM_LEVELS; k++) begin
         kmask = ~({CW{1'b1}} << k);
         first = (count_ff & kmask) == '0;
         full  = (count_ff & kmask) == kmask;
         if (first) begin
            lvl_min_in[k] = sample_i;
            lvl_max_in[k] = sample_i;
         end else begin
            lvl_min_in[k] = (sample_i < lvl_min_ff[k]) ? sample_i : lvl_min_ff[k];
            lvl_max_in[k] = (sample_i > lvl_max_ff[k]) ? sample_i : lvl_max_ff[k];
         end
         emit_mask[k]  = (mmd_pkg::CFG_WIDTH'(k) < used) && (full || stream_end_i);
         flush_mask[k] = !full;
         min_flat[k*SAMPLE_WIDTH +: SAMPLE_WIDTH] = lvl_min_in[k];
         max_flat[k*SAMPLE_WIDTH +: SAMPLE_WIDTH] = lvl_max_in[k];
      end
   end

   assign push_data_o = {max_flat, min_flat, flush_mask, emit_mask};
   assign count_in    = stream_end_i ? '0 : count_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lvl_min_ff <= lvl_min_in;
         lvl_max_ff <= lvl_max_in;
      end
   end

   // Level zero fills on every sample, so every sample releases a result.
   a_level0_emits: assert property (@(posedge clock) disable iff (reset)
      push_o |-> push_data_o[0])
      else $error("sample pushed without a level zero result");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && stream_end_i |=> count_ff == '0)
      else $error("sample count did not restart after stream end");

endmodule

### src/mmd_queue.sv
// Short queue between the front and the back of the decimator.
// Holds classified samples with their level snapshots. Depends on mmd_pkg.
module mmd_queue #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_i,
   input  logic [DATA_WIDTH-1:0] push_data_i,
   output logic                  full_o,
   input  logic                  pop_i,
   output logic                  head_valid_o,
   output logic [DATA_WIDTH-1:0] head_data_o
);

   localparam int PW = (mmd_pkg::QUEUE_DEPTH > 1) ? $clog2(mmd_pkg::QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(mmd_pkg::QUEUE_DEPTH + 1);

   logic [DATA_WIDTH-1:0] entry_ff [mmd_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] fill_ff, fill_in;

   assign full_o       = fill_ff == NW'(mmd_pkg::QUEUE_DEPTH);
   assign head_valid_o = fill_ff != '0;
   assign head_data_o  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == PW'(mmd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == PW'(mmd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push_i && !pop_i) begin
         fill_in = fill_ff + NW'(1);
      end else if (pop_i && !push_i) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         entry_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> !full_o)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> head_valid_o)
      else $error("pop from an empty queue");

endmodule

### src/mmd_back.sv
// Back part: walks the released levels of the queue head in ascending order
// and drives one result per transfer from an output register. Depends on mmd_pkg.
module mmd_back #(
   parameter int NUM_LEVELS   = mmd_pkg::NUM_LEVELS_DEFAULT,
   parameter int SAMPLE_WIDTH = mmd_pkg::SAMPLE_WIDTH_DEFAULT,
   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1,
   localparam int EW = 2 * NUM_LEVELS + 2 * NUM_LEVELS * SAMPLE_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid_i,
   input  logic [EW-1:0]           head_data_i,
   output logic                    pop_o,
   output logic                    rsp_valid_o,
   input  logic                    rsp_ready_i,
   output logic [LW-1:0]           level_o,
   output logic [SAMPLE_WIDTH-1:0] min_o,
   output logic [SAMPLE_WIDTH-1:0] max_o,
   output logic                    last_o,
   output logic                    flush_o
);

   logic [NUM_LEVELS-1:0] head_mask;
   logic [NUM_LEVELS-1:0] head_flush;
   logic [NUM_LEVELS-1:0] done_ff, done_in;
   logic [NUM_LEVELS-1:0] remaining;
   logic [NUM_LEVELS-1:0] lowest;
   logic [NUM_LEVELS-1:0] after;
   logic [LW-1:0] sel;
   logic load;

   logic                    rsp_valid_ff;
   logic [LW-1:0]           level_ff;
   logic [SAMPLE_WIDTH-1:0] min_ff;
   logic [SAMPLE_WIDTH-1:0] max_ff;
   logic                    last_ff;
   logic                    flush_ff;

   assign head_mask  = head_data_i[NUM_LEVELS-1:0];
   assign head_flush = head_data_i[2*NUM_LEVELS-1:NUM_LEVELS];
   assign remaining  = head_mask & ~done_ff;
   assign lowest     = remaining & (~remaining + NUM_LEVELS'(1));
   assign after      = remaining & ~lowest;

   always_comb begin
      sel = '0;
      for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
         if (remaining[k]) begin
            sel = LW'(k);
         end
      end
   end

   // The output register takes a new result whenever it is empty or drained.
   assign load    = head_valid_i && (!rsp_valid_ff || rsp_ready_i);
   assign pop_o   = load && (after == '0);
   assign done_in = (after == '0) ? '0 : (done_ff | lowest);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            done_ff <= done_in;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready_i) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         level_ff <= sel;
         min_ff   <= head_data_i[2*NUM_LEVELS + 32'(sel)*SAMPLE_WIDTH +: SAMPLE_WIDTH];
         max_ff   <= head_data_i[2*NUM_LEVELS + NUM_LEVELS*SAMPLE_WIDTH
                                 + 32'(sel)*SAMPLE_WIDTH +: SAMPLE_WIDTH];
         last_ff  <= after == '0;
         flush_ff <= head_flush[sel];
      end
   end

   assign rsp_valid_o = rsp_valid_ff;
   assign level_o     = level_ff;
   assign min_o       = min_ff;
   assign max_o       = max_ff;
   assign last_o      = last_ff;
   assign flush_o     = flush_ff;

   // Every queued sample carries at least one released level.
   a_head_has_work: assert property (@(posedge clock) disable iff (reset)
      head_valid_i |-> remaining != '0)
      else $error("queue head has no level left to send");

   a_last_pops: assert property (@(posedge clock) disable iff (reset)
      load |=> last_ff == $past(pop_o))
      else $error("run end flag disagrees with queue pop");

endmodule

### src/multilevel_minmax_decimator_core.sv
// Multilevel min/max decimator, top level with the configuration registers.
// Path: a sample is written into the queue, then its results load the output register.
// Throughput: one result per cycle while rsp_tready is high; a sample releases one result
// per level whose bucket fills or, on a stream end, is flushed (up to NUM_LEVELS), and the
// back sends them in turn; a two-entry queue lets the front take samples meanwhile.
// Reset clears the sample count, queue and output; levels_in_use returns to 16.
module multilevel_minmax_decimator_core #(
   parameter int NUM_LEVELS   = mmd_pkg::NUM_LEVELS_DEFAULT,
   parameter int SAMPLE_WIDTH = mmd_pkg::SAMPLE_WIDTH_DEFAULT,
   localparam int LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1,
   localparam int IDW = ((SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int ODW = ((LW + 2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [IDW-1:0]                      req_tdata,  // sample_value
   input  logic                                req_tlast,  // stream_end
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ODW-1:0]                      rsp_tdata,  // level_index, min_value, max_value
   output logic                                rsp_tlast,  // run_last
   output logic                                rsp_tuser,  // final_flush
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mmd_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [mmd_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [mmd_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int EW = 2 * NUM_LEVELS + 2 * NUM_LEVELS * SAMPLE_WIDTH;

   logic [mmd_pkg::CFG_WIDTH-1:0] levels_in_use_ff;
   logic csr_write;
   logic queue_full;
   logic push;
   logic [EW-1:0] push_data;
   logic pop;
   logic head_valid;
   logic [EW-1:0] head_data;
   logic [LW-1:0] level;
   logic [SAMPLE_WIDTH-1:0] min_val;
   logic [SAMPLE_WIDTH-1:0] max_val;

   // Register decode uses the word index of the byte address.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == mmd_pkg::REG_LEVELS_IN_USE);

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_in_use_ff <= mmd_pkg::LEVELS_IN_USE_RESET;
      end else if (csr_write) begin
         levels_in_use_ff <= csr_pwdata[mmd_pkg::CFG_WIDTH-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == mmd_pkg::REG_LEVELS_IN_USE) begin
         csr_prdata = mmd_pkg::CSR_DATA_WIDTH'(levels_in_use_ff);
      end
   end

   mmd_front #(
      .NUM_LEVELS   (NUM_LEVELS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .levels_in_use_i (levels_in_use_ff),
      .sample_valid_i  (req_tvalid),
      .sample_ready_o  (req_tready),
      .sample_i        (req_tdata[SAMPLE_WIDTH-1:0]),
      .stream_end_i    (req_tlast),
      .queue_full_i    (queue_full),
      .push_o          (push),
      .push_data_o     (push_data)
   );

   mmd_queue #(
      .DATA_WIDTH (EW)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_i       (push),
      .push_data_i  (push_data),
      .full_o       (queue_full),
      .pop_i        (pop),
      .head_valid_o (head_valid),
      .head_data_o  (head_data)
   );

   mmd_back #(
      .NUM_LEVELS   (NUM_LEVELS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid_i (head_valid),
      .head_data_i  (head_data),
      .pop_o        (pop),
      .rsp_valid_o  (rsp_tvalid),
      .rsp_ready_i  (rsp_tready),
      .level_o      (level),
      .min_o        (min_val),
      .max_o        (max_val),
      .last_o       (rsp_tlast),
      .flush_o      (rsp_tuser)
   );

   assign rsp_tdata = ODW'({max_val, min_val, level});

endmodule
